// ===== rtl/core/macroblock_tile_detile_address_unit_assert.svh =====
// Assertion macros shared by the macroblock tile address RTL.
`ifndef MACROBLOCK_TILE_DETILE_ADDRESS_UNIT_ASSERT_SVH
`define MACROBLOCK_TILE_DETILE_ADDRESS_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define MBTD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mbtd assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define MBTD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mbtd assertion failed");

`endif

// ===== rtl/core/mbtd_pkg.sv =====
// Types and constants of the macroblock tile address unit.
package mbtd_pkg;

   localparam int KIND_W     = 2;
   localparam int COORD_W    = 11;
   localparam int SIZE_W     = 12;
   localparam int OUT_ADDR_W = 23;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   // Widest unwrapped address: chroma base plus the largest plane offset.
   localparam int SUM_W      = 26;
   localparam int CBASE_W    = 25;

   localparam logic [KIND_W-1:0] KIND_LUMA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CB   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CR   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 12'd1280;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 12'd720;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } pos_type;

endpackage

// ===== rtl/core/macroblock_tile_detile_address_unit.sv =====
// Top level: raster pixel position to macroblock-tiled byte address.
//
//  channel | dir | tdata (low bit up)          | tuser
//  req_    | in  | column[10:0], row[21:11]    | kind[1:0]
//  rsp_    | out | byte_address[22:0]          | out_of_range
//  csr_    | in  | csr_wdata = frame width / frame height (12 bits), no read-back
//
// One item per cycle sustained while rsp_ is ready; an accepted item passes the input register,
// then the result register, which drives rsp_tvalid.
// The address path is one 7x12 multiply plus a short add tree; the chroma base
// multiply runs off the size registers and is registered.
// Synchronous reset clears valids and sets the sizes to 1280 x 720.
// When rsp_ stalls, one more item is held in the input register before req_tready drops.
module macroblock_tile_detile_address_unit #(
   parameter int ADDRESS_BITS = 23
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mbtd_pkg::REQ_DATA_W-1:0]    req_tdata,   // column, row, zero pad
   input  logic [mbtd_pkg::KIND_W-1:0]        req_tuser,   // kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mbtd_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // byte_address, zero pad
   output logic                               rsp_tuser,   // out_of_range
   input  logic                               csr_we,
   input  logic [mbtd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mbtd_pkg::SIZE_W-1:0]        csr_wdata
);
   import mbtd_pkg::*;

   logic [SIZE_W-1:0]     width_ff, width_in;
   logic [SIZE_W-1:0]     height_ff, height_in;
   logic [CBASE_W-1:0]    cbase_ff, cbase_in;
   logic [SIZE_W-1:0]     luma_cols_ff, luma_rows_ff;
   logic [COORD_W-1:0]    chroma_cols_ff, chroma_rows_ff;

   logic                  in_valid_ff, in_valid_in;
   pos_type               pos_ff, pos_in;
   logic                  out_valid_ff, out_valid_in;
   logic [OUT_ADDR_W-1:0] addr_ff, addr_in;
   logic                  oor_ff, oor_in;

   logic                  out_free, in_advance;
   logic                  is_luma, is_chroma, in_grid;
   logic [6:0]            pair_rows;
   logic [18:0]           pair_prod;
   logic [SUM_W-1:0]      pair_off, mb_off, sum, wrap_mask, wrapped;
   logic [8:0]            inner;
   logic [7:0]            cbase_rows;

   // ---------------- configuration ----------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && csr_index == REG_FRAME_WIDTH) begin
         width_in = csr_wdata;
      end
      if (csr_we && csr_index == REG_FRAME_HEIGHT) begin
         height_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Derived sizes are registered from the size registers; the block does not hold items back while they settle.
   assign cbase_rows = 8'((13'(height_ff) + 13'd16) >> 5);
   assign cbase_in   = CBASE_W'(20'(cbase_rows) * 20'(width_ff)) << 5;

   always_ff @(posedge clock) begin
      cbase_ff       <= cbase_in;
      luma_cols_ff   <= {width_ff[11:4], 4'b0};
      luma_rows_ff   <= {height_ff[11:4], 4'b0};
      chroma_cols_ff <= {width_ff[11:5], 4'b0};
      chroma_rows_ff <= {height_ff[11:4], 3'b0};
   end

   // ---------------- handshake ----------------
   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_advance = !in_valid_ff || out_free;
   assign req_tready = in_advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      if (in_advance) begin
         in_valid_in = req_tvalid;
         pos_in      = '{kind: req_tuser, column: req_tdata[10:0], row: req_tdata[21:11]};
      end
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   // ---------------- address ----------------
   assign is_luma   = pos_ff.kind == KIND_LUMA;
   assign is_chroma = pos_ff.kind == KIND_CB || pos_ff.kind == KIND_CR;
   assign in_grid   = is_luma
      ? (SIZE_W'(pos_ff.column) < luma_cols_ff && SIZE_W'(pos_ff.row) < luma_rows_ff)
      : (is_chroma && pos_ff.column < chroma_cols_ff && pos_ff.row < chroma_rows_ff);

   // Pairs of macroblock rows: luma 32 lines apart at w*32, chroma 16 at w*16.
   assign pair_rows = is_luma ? {1'b0, pos_ff.row[10:5]} : pos_ff.row[10:4];
   assign pair_prod = 19'(pair_rows) * 19'(width_ff);
   assign pair_off  = is_luma ? (SUM_W'(pair_prod) << 5) : (SUM_W'(pair_prod) << 4);

   // Macroblock column plus odd macroblock row.
   assign mb_off = (SUM_W'(pos_ff.column[10:4]) << 9)
                 | (SUM_W'(is_luma ? pos_ff.row[4] : pos_ff.row[3]) << 8);

   // Inside the macroblock: line interleave, column groups reversed in fours.
   always_comb begin
      if (is_luma) begin
         inner = 9'({pos_ff.row[3:2], 4'b0})
               + (pos_ff.row[0] ? 9'h080 : 9'h000)
               + (pos_ff.row[1] ? 9'h000 : 9'h008)
               + (pos_ff.column[3] ? 9'h040 : 9'h000)
               + (pos_ff.column[2] ? 9'h000 : 9'h004)
               + {7'b0, ~pos_ff.column[1:0]};
      end else begin
         inner = (pos_ff.row[2] ? 9'h010 : 9'h000)
               + (pos_ff.row[0] ? 9'h040 : 9'h000)
               + (pos_ff.row[1] ? 9'h000 : 9'h008)
               + ((pos_ff.kind == KIND_CB) ? 9'h004 : 9'h000)
               + (pos_ff.column[2] ? 9'h020 : 9'h000)
               + (pos_ff.column[3] ? 9'h080 : 9'h000)
               + {7'b0, ~pos_ff.column[1:0]};
      end
   end

   assign sum = (is_luma ? '0 : SUM_W'(cbase_ff)) + pair_off + mb_off + SUM_W'(inner);

   always_comb begin
      for (int i = 0; i < SUM_W; i++) begin
         wrap_mask[i] = i < ADDRESS_BITS;
      end
   end

   assign wrapped = sum & wrap_mask;
   assign addr_in = in_grid ? wrapped[OUT_ADDR_W-1:0] : '0;
   assign oor_in  = !in_grid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (out_free) begin
         addr_ff <= addr_in;
         oor_ff  <= oor_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(addr_ff);
   assign rsp_tuser  = oor_ff;

   // ---------------- checks ----------------
`include "macroblock_tile_detile_address_unit_assert.svh"

   `MBTD_ASSERT_NOW(a_oor_zero_addr, out_valid_ff && oor_ff, addr_ff == '0)
   `MBTD_ASSERT_NOW(a_ready_only_full, !req_tready, in_valid_ff && out_valid_ff)
   `MBTD_ASSERT_NEXT(a_bad_kind_oor, in_valid_ff && out_free && pos_ff.kind == KIND_NONE, oor_ff)
   `MBTD_ASSERT_NEXT(a_no_phantom, !in_valid_ff && out_free, !out_valid_ff)

endmodule
